// ===== src/ljx_pkg.sv =====
package ljx_pkg;

	// Port field widths
	localparam int TYPE_W   = 8;
	localparam int RADIUS_W = 16;
	localparam int WELL_W   = 16;
	localparam int RSTAR_W  = 21;
	localparam int COEF_A_W = 63;
	localparam int COEF_C_W = 48;

	// Internal datapath widths, each sized to the largest value the inputs can produce
	localparam int WPROD_W    = 2 * WELL_W;        // well_a * well_b
	localparam int SQRT_RAD_W = WPROD_W + 16;      // product scaled by 2^16
	localparam int ROOT_W     = SQRT_RAD_W / 2;    // mean well, 2^-20 kJ/mol
	localparam int R2_W       = 41;                // rstar^2 < 2^41
	localparam int R3_W       = 61;                // rstar^3 < 2^61
	localparam int R6_W       = 58;                // R^6 in 2^-32 units < 2^58
	localparam int EPS_W      = 22;                // eps in 2^-20 kcal/mol
	localparam int T_W        = 48;                // eps*R^6 in 2^-20 units
	localparam int A_W        = 62;                // A never reaches 2^62

	// kJ -> kcal: round(g * 125 / 523) = floor((g*250 + 523) / 1046)
	localparam int EPS_SCALE   = 250;
	localparam int EPS_BIAS    = 523;
	localparam int EPS_DIV     = 1046;
	localparam int RECIP_SHIFT = 42;
	localparam logic [31:0] RECIP_M = 32'((64'd1 << RECIP_SHIFT) / EPS_DIV);

	localparam logic [RSTAR_W-1:0] RSTAR_MAX = RSTAR_W'(1310700);

	// Fields that ride alongside the square root
	typedef struct packed {
		logic [TYPE_W-1:0]  type_a;
		logic [TYPE_W-1:0]  type_b;
		logic [RSTAR_W-1:0] rstar;
		logic [R6_W-1:0]    r6;
	} side_t;

endpackage

// ===== src/ljx_isqrt_pipe.sv =====
// Pipelined integer square root, two root bits per stage.
// RAD_W must be a multiple of four.
module ljx_isqrt_pipe #(
	parameter int RAD_W = ljx_pkg::SQRT_RAD_W
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [RAD_W-1:0]     in_rad,
	input  ljx_pkg::side_t       in_side,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [RAD_W/2-1:0]   out_root,
	output ljx_pkg::side_t       out_side
);
	import ljx_pkg::*;

	localparam int ROOT_BITS    = RAD_W / 2;
	localparam int BITS_PER_STG = 2;
	localparam int NSTG         = ROOT_BITS / BITS_PER_STG;
	localparam int REM_W        = ROOT_BITS + 2;

	typedef struct packed {
		logic [RAD_W-1:0]     rad;
		logic [REM_W-1:0]     rem;
		logic [ROOT_BITS-1:0] root;
	} sq_t;

	// One restoring step: bring down two radicand bits, try root*4+1.
	function automatic sq_t sq_step(sq_t cur);
		sq_t              nxt;
		logic [REM_W-1:0] rem_n;
		logic [REM_W-1:0] trial;
		rem_n   = {cur.rem[REM_W-3:0], cur.rad[RAD_W-1 -: 2]};
		trial   = {cur.root, 2'b01};
		nxt.rad = {cur.rad[RAD_W-3:0], 2'b00};
		if (rem_n >= trial) begin
			nxt.rem  = rem_n - trial;
			nxt.root = {cur.root[ROOT_BITS-2:0], 1'b1};
		end else begin
			nxt.rem  = rem_n;
			nxt.root = {cur.root[ROOT_BITS-2:0], 1'b0};
		end
		return nxt;
	endfunction

	sq_t             st_s   [NSTG];
	side_t           side_s [NSTG];
	logic [NSTG-1:0] vld_s;
	sq_t             src    [NSTG];
	side_t           side_src [NSTG];
	logic [NSTG-1:0] vld_src;
	logic [NSTG:0]   en;

	always_comb begin
		src[0]      = '{rad: in_rad, rem: '0, root: '0};
		side_src[0] = in_side;
		for (int k = 1; k < NSTG; k++) begin
			src[k]      = st_s[k-1];
			side_src[k] = side_s[k-1];
		end
	end

	assign vld_src  = {vld_s[NSTG-2:0], in_valid};
	assign en[NSTG] = out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < NSTG; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_src[k];
				end
			end
		end
	end

	for (genvar k = 0; k < NSTG; k++) begin : g_stg
		// advance a stage when it is empty or its successor moves
		assign en[k] = ~vld_s[k] | en[k+1];

		always_ff @(posedge clk) begin
			if (en[k]) begin
				st_s[k]   <= sq_step(sq_step(src[k]));
				side_s[k] <= side_src[k];
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_s[NSTG-1];
	assign out_root  = st_s[NSTG-1].root;
	assign out_side  = side_s[NSTG-1];

endmodule

// ===== src/lj_cross_term_mixing.sv =====
// Channel        | Dir | Payload (tdata, lowest bit first)
// s_axis (input) | in  | type_a[7:0] type_b[15:8] radius_a[31:16] radius_b[47:32]
//                |     | well_a[63:48] well_b[79:64]
// m_axis (result)| out | pair_a[7:0] pair_b[15:8] rstar[36:16] coef_repulsive[99:37]
//                |     | coef_attractive[147:100], zero fill [151:148]
//
// Throughput: one transfer per cycle on each side while m_axis is not stalled; 27 register
// stages lie between the input transfer and the result on m_axis: the 12-stage square root
// of the well product (two root bits per stage) sits between six radius stages in front
// and nine scaling/multiply stages behind.
// Reset: arst_n clears only the stage valid bits; the datapath registers are not reset.
// Stalls: each stage holds while its successor is full and stalled; empty stages
// keep filling, so the input keeps taking transfers while a result waits, until every stage is full.
module lj_cross_term_mixing (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [79:0]  s_axis_tdata,   // type_a, type_b, radius_a, radius_b, well_a, well_b
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [151:0] m_axis_tdata    // pair_a, pair_b, rstar, coef_repulsive,
	                                     // coef_attractive, zero fill
);
	import ljx_pkg::*;

	localparam int R6_LO_W = R6_W / 2;
	localparam int T_LO_W  = T_W / 2;
	localparam int PT_W    = EPS_W + R6_LO_W;          // eps * half of R^6
	localparam int TS_W    = PT_W + R6_LO_W + 1;       // eps * R^6 plus rounding
	localparam int PP_W    = T_LO_W + R6_LO_W;         // one quarter product of t * R^6
	localparam int SA_W    = PP_W + R6_LO_W + 1;
	localparam int SB_W    = PP_W + R6_LO_W + T_LO_W + 1;
	localparam int AS_W    = SB_W + 1;
	localparam int LOW_W   = 95;                       // low part of r3^2 plus rounding

	localparam logic [TS_W-1:0]  T_RND  = TS_W'(1)  << 31;
	localparam logic [SA_W-1:0]  A_RND  = SA_W'(1)  << 43;
	localparam logic [LOW_W-1:0] R6_RND = LOW_W'(1) << 63;

	// Input field extraction
	logic [TYPE_W-1:0]   in_type_a, in_type_b;
	logic [RADIUS_W-1:0] in_radius_a, in_radius_b;
	logic [WELL_W-1:0]   in_well_a, in_well_b;

	assign in_type_a   = s_axis_tdata[7:0];
	assign in_type_b   = s_axis_tdata[15:8];
	assign in_radius_a = s_axis_tdata[31:16];
	assign in_radius_b = s_axis_tdata[47:32];
	assign in_well_a   = s_axis_tdata[63:48];
	assign in_well_b   = s_axis_tdata[79:64];

	// ---------------------------------------------------------------------
	// Handshake: valid bits per stage, enables ripple back from the output
	// ---------------------------------------------------------------------
	logic [6:1]   front_vld_s;
	logic [6:1]   front_en;
	logic [27:19] back_vld_s;
	logic [27:19] back_en;
	logic         sq_in_ready, sq_out_valid;

	assign front_en[6] = ~front_vld_s[6] | sq_in_ready;
	for (genvar k = 1; k < 6; k++) begin : g_front_en
		assign front_en[k] = ~front_vld_s[k] | front_en[k+1];
	end

	assign back_en[27] = ~back_vld_s[27] | m_axis_tready;
	for (genvar k = 19; k < 27; k++) begin : g_back_en
		assign back_en[k] = ~back_vld_s[k] | back_en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_vld_s <= '0;
			back_vld_s  <= '0;
		end else begin
			if (front_en[1]) begin
				front_vld_s[1] <= s_axis_tvalid;
			end
			for (int k = 2; k <= 6; k++) begin
				if (front_en[k]) begin
					front_vld_s[k] <= front_vld_s[k-1];
				end
			end
			if (back_en[19]) begin
				back_vld_s[19] <= sq_out_valid;
			end
			for (int k = 20; k <= 27; k++) begin
				if (back_en[k]) begin
					back_vld_s[k] <= back_vld_s[k-1];
				end
			end
		end
	end

	assign s_axis_tready = front_en[1];

	// ---------------------------------------------------------------------
	// Front: combined radius and R^6, well product carried along
	// ---------------------------------------------------------------------
	logic [TYPE_W-1:0]  type_a_s1, type_b_s1, type_a_s2, type_b_s2, type_a_s3, type_b_s3;
	logic [TYPE_W-1:0]  type_a_s4, type_b_s4, type_a_s5, type_b_s5, type_a_s6, type_b_s6;
	logic [WPROD_W-1:0] wprod_s1, wprod_s2, wprod_s3, wprod_s4, wprod_s5, wprod_s6;
	logic [RSTAR_W-1:0] rstar_s1, rstar_s2, rstar_s3, rstar_s4, rstar_s5, rstar_s6;
	logic [R2_W-1:0]    r2_s2;
	logic [R3_W-1:0]    r3_s3;
	logic [63:0]        ll_s4;
	logic [60:0]        lh_s4;
	logic [R6_W-1:0]    hh_s4, hh_s5, r6_s6;
	logic [LOW_W-1:0]   low_s5;

	logic [RADIUS_W:0]      rsum;
	logic [2*RSTAR_W-1:0]   r2_full;
	logic [R2_W+RSTAR_W-1:0] r3_full;

	assign rsum    = {1'b0, in_radius_a} + {1'b0, in_radius_b};
	assign r2_full = {{RSTAR_W{1'b0}}, rstar_s1} * {{RSTAR_W{1'b0}}, rstar_s1};
	assign r3_full = {{RSTAR_W{1'b0}}, r2_s2} * {{R2_W{1'b0}}, rstar_s2};

	always_ff @(posedge clk) begin
		if (front_en[1]) begin
			type_a_s1 <= in_type_a;
			type_b_s1 <= in_type_b;
			// 10x = 8x + 2x
			rstar_s1  <= (RSTAR_W'(rsum) << 3) + (RSTAR_W'(rsum) << 1);
			wprod_s1  <= {{WELL_W{1'b0}}, in_well_a} * {{WELL_W{1'b0}}, in_well_b};
		end
		if (front_en[2]) begin
			type_a_s2 <= type_a_s1;
			type_b_s2 <= type_b_s1;
			rstar_s2  <= rstar_s1;
			wprod_s2  <= wprod_s1;
			r2_s2     <= r2_full[R2_W-1:0];
		end
		if (front_en[3]) begin
			type_a_s3 <= type_a_s2;
			type_b_s3 <= type_b_s2;
			rstar_s3  <= rstar_s2;
			wprod_s3  <= wprod_s2;
			r3_s3     <= r3_full[R3_W-1:0];
		end
		if (front_en[4]) begin
			// r3^2 = hh*2^64 + 2*lh*2^32 + ll
			type_a_s4 <= type_a_s3;
			type_b_s4 <= type_b_s3;
			rstar_s4  <= rstar_s3;
			wprod_s4  <= wprod_s3;
			ll_s4     <= {32'b0, r3_s3[31:0]} * {32'b0, r3_s3[31:0]};
			lh_s4     <= {29'b0, r3_s3[31:0]} * {32'b0, r3_s3[R3_W-1:32]};
			hh_s4     <= {29'b0, r3_s3[R3_W-1:32]} * {29'b0, r3_s3[R3_W-1:32]};
		end
		if (front_en[5]) begin
			type_a_s5 <= type_a_s4;
			type_b_s5 <= type_b_s4;
			rstar_s5  <= rstar_s4;
			wprod_s5  <= wprod_s4;
			hh_s5     <= hh_s4;
			low_s5    <= LOW_W'(ll_s4) + LOW_W'({lh_s4, 33'b0}) + R6_RND;
		end
		if (front_en[6]) begin
			type_a_s6 <= type_a_s5;
			type_b_s6 <= type_b_s5;
			rstar_s6  <= rstar_s5;
			wprod_s6  <= wprod_s5;
			r6_s6     <= hh_s5 + R6_W'(low_s5[LOW_W-1:64]);
		end
	end

	// ---------------------------------------------------------------------
	// Square root of well_a * well_b * 2^16 (stages 7 to 18)
	// ---------------------------------------------------------------------
	side_t             sq_in_side, sq_out_side;
	logic [ROOT_W-1:0] sq_root;

	assign sq_in_side = '{type_a: type_a_s6, type_b: type_b_s6, rstar: rstar_s6, r6: r6_s6};

	ljx_isqrt_pipe #(
		.RAD_W(SQRT_RAD_W)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (front_vld_s[6]),
		.in_ready (sq_in_ready),
		.in_rad   ({wprod_s6, 16'b0}),
		.in_side  (sq_in_side),
		.out_valid(sq_out_valid),
		.out_ready(back_en[19]),
		.out_root (sq_root),
		.out_side (sq_out_side)
	);

	// ---------------------------------------------------------------------
	// Back: eps by reciprocal divide, then eps*R^6 and eps*R^12
	// ---------------------------------------------------------------------
	side_t               side_s19, side_s20, side_s21, side_s22, side_s23, side_s24;
	side_t               side_s25, side_s26, side_s27;
	logic [31:0]         n_s19, n_s20, n_s21;
	logic [63:0]         nm_s20;
	logic [EPS_W-1:0]    q0_s21, eps_s22;
	logic [32:0]         qd_s21;
	logic [PT_W-1:0]     pt_lo_s23, pt_hi_s23;
	logic [T_W-1:0]      t_s24;
	logic [PP_W-1:0]     p00_s25, p01_s25, p10_s25, p11_s25;
	logic [COEF_C_W-1:0] c_s25, c_s26, c_s27;
	logic [SA_W-1:0]     sa_s26;
	logic [SB_W-1:0]     sb_s26;
	logic [A_W-1:0]      a_s27;

	logic [32:0]     rem21;
	logic [TS_W-1:0] tsum;
	logic [AS_W-1:0] asum;

	assign rem21 = {1'b0, n_s21} - qd_s21;
	assign tsum  = TS_W'({pt_hi_s23, {R6_LO_W{1'b0}}}) + TS_W'(pt_lo_s23) + T_RND;
	assign asum  = AS_W'(sa_s26) + AS_W'(sb_s26);

	always_ff @(posedge clk) begin
		if (back_en[19]) begin
			side_s19 <= sq_out_side;
			n_s19    <= 32'(sq_root) * 32'(EPS_SCALE) + 32'(EPS_BIAS);
		end
		if (back_en[20]) begin
			side_s20 <= side_s19;
			n_s20    <= n_s19;
			nm_s20   <= {32'b0, n_s19} * {32'b0, RECIP_M};
		end
		if (back_en[21]) begin
			// quotient estimate is exact or one low
			side_s21 <= side_s20;
			n_s21    <= n_s20;
			q0_s21   <= nm_s20[63:RECIP_SHIFT];
			qd_s21   <= 33'(nm_s20[63:RECIP_SHIFT]) * 33'(EPS_DIV);
		end
		if (back_en[22]) begin
			side_s22 <= side_s21;
			eps_s22  <= q0_s21 + EPS_W'(rem21 >= 33'(EPS_DIV));
		end
		if (back_en[23]) begin
			side_s23  <= side_s22;
			pt_lo_s23 <= PT_W'(eps_s22) * PT_W'(side_s22.r6[R6_LO_W-1:0]);
			pt_hi_s23 <= PT_W'(eps_s22) * PT_W'(side_s22.r6[R6_W-1:R6_LO_W]);
		end
		if (back_en[24]) begin
			side_s24 <= side_s23;
			t_s24    <= tsum[T_W+31:32];
		end
		if (back_en[25]) begin
			side_s25 <= side_s24;
			p00_s25  <= PP_W'(t_s24[T_LO_W-1:0]) * PP_W'(side_s24.r6[R6_LO_W-1:0]);
			p01_s25  <= PP_W'(t_s24[T_LO_W-1:0]) * PP_W'(side_s24.r6[R6_W-1:R6_LO_W]);
			p10_s25  <= PP_W'(t_s24[T_W-1:T_LO_W]) * PP_W'(side_s24.r6[R6_LO_W-1:0]);
			p11_s25  <= PP_W'(t_s24[T_W-1:T_LO_W]) * PP_W'(side_s24.r6[R6_W-1:R6_LO_W]);
			// C = round(t / 8), half up
			c_s25    <= COEF_C_W'(t_s24[T_W-1:3]) + COEF_C_W'(t_s24[2]);
		end
		if (back_en[26]) begin
			side_s26 <= side_s25;
			c_s26    <= c_s25;
			sa_s26   <= SA_W'(p00_s25) + SA_W'({p01_s25, {R6_LO_W{1'b0}}}) + A_RND;
			sb_s26   <= SB_W'({p10_s25, {T_LO_W{1'b0}}})
			          + SB_W'({p11_s25, {(R6_LO_W + T_LO_W){1'b0}}});
		end
		if (back_en[27]) begin
			// A stays below 2^62 for every input, so no clamp is needed
			side_s27 <= side_s26;
			c_s27    <= c_s26;
			a_s27    <= asum[A_W+43:44];
		end
	end

	assign m_axis_tvalid = back_vld_s[27];
	assign m_axis_tdata  = {4'b0, c_s27, 1'b0, a_s27,
	                        side_s27.rstar, side_s27.type_b, side_s27.type_a};

	// ---------------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------------
	// a drained or draining output must open the whole enable chain
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
		else $error("input stalled while output free");

	a_rstar_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[36:16] <= RSTAR_MAX))
		else $error("rstar out of range");

	// A stays below 2^62, C below 2^45
	a_coef_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (!m_axis_tdata[99] && m_axis_tdata[147:145] == 3'b0))
		else $error("coefficient above its bound");

	a_zero_radius: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[36:16] == '0)
		|-> (m_axis_tdata[99:37] == '0 && m_axis_tdata[147:100] == '0))
		else $error("nonzero coefficient at zero radius");

endmodule

// ===== verif/lj_cross_term_mixing_tb.sv =====
module lj_cross_term_mixing_tb;

	import ljx_pkg::*;

	// Number of register stages in the block, from the block's header
	localparam int PIPE_DEPTH = 27;
	localparam int IDLE_PCT   = 8;

	localparam logic [COEF_A_W-1:0] COEF_A_SAT = '1;
	localparam logic [COEF_C_W-1:0] COEF_C_SAT = '1;

	// One pair of atom types as it enters the block
	typedef struct packed {
		logic [WELL_W-1:0]   well_b;
		logic [WELL_W-1:0]   well_a;
		logic [RADIUS_W-1:0] radius_b;
		logic [RADIUS_W-1:0] radius_a;
		logic [TYPE_W-1:0]   type_b;
		logic [TYPE_W-1:0]   type_a;
	} type_pair_t;

	// One mixed cross term as it leaves the block, highest field first
	typedef struct packed {
		logic [COEF_C_W-1:0] coef_att;
		logic [COEF_A_W-1:0] coef_rep;
		logic [RSTAR_W-1:0]  rstar;
		logic [TYPE_W-1:0]   pair_b;
		logic [TYPE_W-1:0]   pair_a;
	} cross_term_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [79:0]  s_axis_tdata;   // type_a, type_b, radius_a, radius_b, well_a, well_b
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [151:0] m_axis_tdata;   // pair_a, pair_b, rstar, coef_repulsive,
	                              // coef_attractive, zero fill

	cross_term_t pending_terms[$];
	int unsigned mismatch_count;
	bit          steady;          // suppress idling on both sides

	lj_cross_term_mixing i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run of every stimulus item
	initial begin
		#4000000;
		$display("CHECKS FAILED");
		$finish;
	end

	// 128-bit product, round half up, shift right, clamp to 64 bits
	function automatic logic [63:0] mul_round_shift(input logic [63:0] x,
			input logic [63:0] y, input int unsigned sh);
		logic [128:0] prod;
		prod = x;
		prod = prod * y;
		prod = prod + (129'd1 << (sh - 1));
		prod = prod >> sh;
		if (prod[128:64] != '0) begin
			return '1;
		end
		return prod[63:0];
	endfunction

	// Lorentz-Berthelot mix of one type pair into A and C coefficients
	function automatic cross_term_t mix_cross_term(input type_pair_t p);
		cross_term_t  term;
		logic [63:0]  rad, root, probe, mean_well, eps, r3, r6, eps_r6, rep, att;
		rad  = 64'd10 * (64'(p.radius_a) + 64'(p.radius_b));
		// Integer square root of the scaled well product, two bits per pass
		mean_well = (64'(p.well_a) * 64'(p.well_b)) << 16;
		root  = '0;
		probe = 64'd1 << 62;
		while (probe > mean_well) probe = probe >> 2;
		while (probe != 0) begin
			if (mean_well >= root + probe) begin
				mean_well = mean_well - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		// kJ to kcal: times 125/523, rounded half up
		eps    = (root * EPS_SCALE + EPS_BIAS) / EPS_DIV;
		r3     = rad * rad * rad;
		r6     = mul_round_shift(r3, r3, 64);
		eps_r6 = mul_round_shift(eps, r6, 32);
		rep    = mul_round_shift(eps_r6, r6, 44);
		att    = (eps_r6 >> 3) + 64'(eps_r6[2]);
		term.pair_a   = p.type_a;
		term.pair_b   = p.type_b;
		term.rstar    = rad[RSTAR_W-1:0];
		term.coef_rep = (rep > 64'(COEF_A_SAT)) ? COEF_A_SAT : rep[COEF_A_W-1:0];
		term.coef_att = (att > 64'(COEF_C_SAT)) ? COEF_C_SAT : att[COEF_C_W-1:0];
		return term;
	endfunction

	function automatic type_pair_t random_pair();
		type_pair_t p;
		p.type_a   = TYPE_W'($urandom);
		p.type_b   = TYPE_W'($urandom);
		p.radius_a = RADIUS_W'($urandom);
		p.radius_b = RADIUS_W'($urandom);
		p.well_a   = WELL_W'($urandom);
		p.well_b   = WELL_W'($urandom);
		return p;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatch_count++;
		$display("[%0t] mismatch %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
	endtask

	// Offer one pair and hold it until the block takes the transfer
	task automatic send_pair(input type_pair_t p);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= p;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_terms.insert(pending_terms.size(), mix_cross_term(p));
	endtask

	// Stall the result side at random unless a steady stretch is running
	always @(posedge clk) begin
		m_axis_tready <= arst_n && (steady || $urandom_range(99) >= IDLE_PCT);
	end

	// Match every result transfer against the oldest pending cross term
	always @(posedge clk) begin : result_check
		cross_term_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[147:0];
			if (pending_terms.size() == 0) begin
				report_mismatch("result with no pending pair", 64'(got.pair_a), '0);
			end else begin
				want = pending_terms.pop_front();
				if (got.pair_a !== want.pair_a)
					report_mismatch("pair_a", 64'(got.pair_a), 64'(want.pair_a));
				if (got.pair_b !== want.pair_b)
					report_mismatch("pair_b", 64'(got.pair_b), 64'(want.pair_b));
				if (got.rstar !== want.rstar)
					report_mismatch("rstar", 64'(got.rstar), 64'(want.rstar));
				if (got.coef_rep !== want.coef_rep)
					report_mismatch("coef_repulsive", 64'(got.coef_rep),
						64'(want.coef_rep));
				if (got.coef_att !== want.coef_att)
					report_mismatch("coef_attractive", 64'(got.coef_att),
						64'(want.coef_att));
			end
		end
	end

	// Corners: zero and full-scale fields, one-sided zeros, unit steps,
	// and one physically typical pair of atom types
	task automatic test_corners();
		type_pair_t p;
		p = '0;                                             send_pair(p);
		p = '1;                                             send_pair(p);
		p = '0; p.well_a = '1; p.well_b = '1;               send_pair(p);
		p = '0; p.radius_a = '1; p.radius_b = '1;           send_pair(p);
		p = '1; p.well_a = '0;                              send_pair(p);
		p = '1; p.well_b = '0;                              send_pair(p);
		p = '1; p.radius_a = '0;                            send_pair(p);
		p = '1; p.radius_b = '0;                            send_pair(p);
		p = '0; p.type_a = '1;                              send_pair(p);
		p = '0; p.type_b = '1;                              send_pair(p);
		p = '0; p.radius_a = 1; p.well_a = 1; p.well_b = 1; send_pair(p);
		p = '0; p.radius_b = 1; p.well_a = 1; p.well_b = 1; send_pair(p);
		p = '0; p.radius_a = 16'h8000; p.radius_b = 16'h8000;
		p.well_a = 16'h8000; p.well_b = 16'h8000;           send_pair(p);
		// carbon-like and oxygen-like radii and wells
		p.type_a = 8'd3; p.type_b = 8'd7;
		p.radius_a = 16'h2B85; p.radius_b = 16'h2666;
		p.well_a = 16'h05C0; p.well_b = 16'h0D00;           send_pair(p);
		p.type_a = 8'd128; p.type_b = 8'd127;
		p.radius_a = 16'h1000; p.radius_b = 16'h4000;
		p.well_a = 16'h0001; p.well_b = 16'hFFFF;           send_pair(p);
		p = '1; p.radius_a = 16'hFFFE;                      send_pair(p);
	endtask

	// Uniform random over every field
	task automatic test_random_full(input int unsigned count);
		repeat (count) send_pair(random_pair());
	endtask

	// Mostly force-field-like values, mixed with full-range noise
	task automatic test_random_typical(input int unsigned count);
		type_pair_t p;
		repeat (count) begin
			p = random_pair();
			if ($urandom_range(3) != 0) begin
				// radii 0.1..0.4 nm, wells up to a few kJ/mol
				p.radius_a = RADIUS_W'($urandom_range(26214, 6554));
				p.radius_b = RADIUS_W'($urandom_range(26214, 6554));
				p.well_a   = WELL_W'($urandom_range(16384, 0));
				p.well_b   = WELL_W'($urandom_range(16384, 0));
			end
			send_pair(p);
		end
	endtask

	// Back-to-back transfers with both sides always ready
	task automatic test_steady_stream(input int unsigned count);
		steady = 1'b1;
		repeat (count) send_pair(random_pair());
		steady = 1'b0;
	endtask

	initial begin
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		steady         = 1'b0;
		mismatch_count = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corners();
		test_random_full(600);
		test_random_typical(500);
		test_steady_stream(480);
		s_axis_tvalid <= 1'b0;

		// Drain the pipe, then give it time to show any stray result
		while (pending_terms.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 20) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
